// File: sv/grayscale_ellipse_ring_overlay_macros.svh
// Assertion macros for the grayscale ellipse ring overlay RTL.
// Included by the top level, which carries the concurrent assertions; no dependencies.
`ifndef GRAYSCALE_ELLIPSE_RING_OVERLAY_MACROS_SVH
`define GRAYSCALE_ELLIPSE_RING_OVERLAY_MACROS_SVH

// Condition and consequence checked at the same clock edge.
`define GERO_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequence checked at the clock edge after the condition.
`define GERO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/gero_pkg.sv
// Types and constants for the grayscale ellipse ring overlay.
// No dependencies; used by gero_cfg_regs and the top level.
`default_nettype none

package gero_pkg;

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row_index;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
  } pixel_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       on_ring;
  } result_t;

  typedef struct packed {
    logic [11:0]        frame_width;
    logic [11:0]        frame_height;
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic [11:0]        radius_x;
    logic [11:0]        radius_y;
  } cfg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_X     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_Y     = 3'd5;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [11:0] RADIUS_X_RST     = 12'd100;
  localparam logic [11:0] RADIUS_Y_RST     = 12'd50;

  // Luma weights as 16-bit fractions; they add up to exactly 1.0.
  localparam logic [15:0] WEIGHT_ZERO = 16'd19661;
  localparam logic [15:0] WEIGHT_ONE  = 16'd38666;
  localparam logic [15:0] WEIGHT_TWO  = 16'd7209;

  // Ring band 0.95 .. 1.05, scaled by 20.
  localparam logic [4:0] RING_LOW   = 5'd19;
  localparam logic [4:0] RING_SCALE = 5'd20;
  localparam logic [4:0] RING_HIGH  = 5'd21;

endpackage

`default_nettype wire

// File: sv/gero_cfg_regs.sv
// Configuration register file of the grayscale ellipse ring overlay.
// Depends on gero_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module gero_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic [gero_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gero_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gero_pkg::cfg_t                         cfg
);

  gero_pkg::cfg_t regs;

  // Writes to indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_width  <= gero_pkg::FRAME_WIDTH_RST;
      regs.frame_height <= gero_pkg::FRAME_HEIGHT_RST;
      regs.center_x     <= '0;
      regs.center_y     <= '0;
      regs.radius_x     <= gero_pkg::RADIUS_X_RST;
      regs.radius_y     <= gero_pkg::RADIUS_Y_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gero_pkg::REG_FRAME_WIDTH:  regs.frame_width  <= cfg_data[11:0];
        gero_pkg::REG_FRAME_HEIGHT: regs.frame_height <= cfg_data[11:0];
        gero_pkg::REG_CENTER_X:     regs.center_x     <= $signed(cfg_data[12:0]);
        gero_pkg::REG_CENTER_Y:     regs.center_y     <= $signed(cfg_data[12:0]);
        gero_pkg::REG_RADIUS_X:     regs.radius_x     <= cfg_data[11:0];
        gero_pkg::REG_RADIUS_Y:     regs.radius_y     <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: sv/grayscale_ellipse_ring_overlay.sv
// Grayscale ellipse ring overlay: a six-stage pixel pipeline.
// Depends on gero_pkg, gero_cfg_regs and grayscale_ellipse_ring_overlay_macros.svh.
//
// Usage:
//   The pixel channel takes one beat per pixel (column, row and three color
//   bytes). The result channel returns one beat per pixel, in order: the
//   gray value, or zero with on_ring set when the pixel falls inside the
//   elliptical ring band. The cfg channel writes one register per beat and
//   is always ready; write only while no pixel is in flight.
//   Throughput is one pixel per clock while the result channel is not
//   stalled. The datapath has six register stages, set by the multiplier
//   chain of the ring test (square, cross product, sum, scale, compare).
//   A stall on the result channel holds each stage that is full; empty
//   stages keep filling, so up to six pixels are buffered before pixel_ready
//   drops. Nothing is dropped or repeated.
//   Reset empties the pipeline and loads the default frame 640 by 480 with a
//   centered ellipse of semi-axes 100 and 50.
`default_nettype none

`include "grayscale_ellipse_ring_overlay_macros.svh"

module grayscale_ellipse_ring_overlay (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pixel_valid,
  output logic                                   pixel_ready,
  input  wire gero_pkg::pixel_t                  pixel,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output gero_pkg::result_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gero_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gero_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gero_pkg::cfg_t cfg;

  gero_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  // Stage valid bits and per-stage advance enables.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !result_valid || result_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pixel_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) v1 <= pixel_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) result_valid <= v5;
    end
  end

  // Stage 1: luma partial products, centered offsets, squared radii.
  logic signed [13:0] dx_c, dy_c;
  logic [22:0] s1_p0;
  logic [23:0] s1_p1;
  logic [20:0] s1_p2;
  logic signed [13:0] s1_dx, s1_dy;
  logic [23:0] s1_a2, s1_b2;

  assign dx_c = {3'b000, pixel.col} - {3'b000, cfg.frame_width[11:1]}
              - {cfg.center_x[12], cfg.center_x};
  assign dy_c = {3'b000, cfg.frame_height[11:1]} - {3'b000, pixel.row_index}
              - {cfg.center_y[12], cfg.center_y};

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_p0 <= 23'(gero_pkg::WEIGHT_ZERO) * 23'(pixel.byte_zero);
      s1_p1 <= 24'(gero_pkg::WEIGHT_ONE) * 24'(pixel.byte_one);
      s1_p2 <= 21'(gero_pkg::WEIGHT_TWO) * 21'(pixel.byte_two);
      s1_dx <= dx_c;
      s1_dy <= dy_c;
      s1_a2 <= 24'(cfg.radius_x) * 24'(cfg.radius_x);
      s1_b2 <= 24'(cfg.radius_y) * 24'(cfg.radius_y);
    end
  end

  // Stage 2: gray value, squared offsets, product of squared radii.
  logic [13:0] dx_neg, dy_neg;
  logic [12:0] dx_mag, dy_mag;
  logic [23:0] luma_sum;
  logic [7:0]  s2_gray;
  logic [25:0] s2_dx2, s2_dy2;
  logic [23:0] s2_a2, s2_b2;
  logic [47:0] s2_ab;

  // Offsets stay within +-6143, so the magnitude fits in 13 bits.
  assign dx_neg = 14'(-s1_dx);
  assign dy_neg = 14'(-s1_dy);
  assign dx_mag = s1_dx[13] ? dx_neg[12:0] : s1_dx[12:0];
  assign dy_mag = s1_dy[13] ? dy_neg[12:0] : s1_dy[12:0];
  assign luma_sum = 24'(s1_p0) + s1_p1 + 24'(s1_p2);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_gray <= luma_sum[23:16];
      s2_dx2  <= 26'(dx_mag) * 26'(dx_mag);
      s2_dy2  <= 26'(dy_mag) * 26'(dy_mag);
      s2_a2   <= s1_a2;
      s2_b2   <= s1_b2;
      s2_ab   <= 48'(s1_a2) * 48'(s1_b2);
    end
  end

  // Stage 3: cross products and band limits.
  logic [7:0]  s3_gray;
  logic [49:0] s3_t1, s3_t2;
  logic [52:0] s3_low, s3_high;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_gray <= s2_gray;
      s3_t1   <= 50'(s2_dx2) * 50'(s2_b2);
      s3_t2   <= 50'(s2_dy2) * 50'(s2_a2);
      s3_low  <= 53'(s2_ab) * 53'(gero_pkg::RING_LOW);
      s3_high <= 53'(s2_ab) * 53'(gero_pkg::RING_HIGH);
    end
  end

  // Stage 4: sum of the weighted squares.
  logic [7:0]  s4_gray;
  logic [50:0] s4_sum;
  logic [52:0] s4_low, s4_high;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_gray <= s3_gray;
      s4_sum  <= 51'(s3_t1) + 51'(s3_t2);
      s4_low  <= s3_low;
      s4_high <= s3_high;
    end
  end

  // Stage 5: scale the sum to the band's denominator.
  logic [7:0]  s5_gray;
  logic [55:0] s5_lhs;
  logic [52:0] s5_low, s5_high;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_gray <= s4_gray;
      s5_lhs  <= 56'(s4_sum) * 56'(gero_pkg::RING_SCALE);
      s5_low  <= s4_low;
      s5_high <= s4_high;
    end
  end

  // Stage 6: band compare into the output register.
  logic ring;

  assign ring = (56'(s5_low) <= s5_lhs) && (s5_lhs <= 56'(s5_high));

  always_ff @(posedge clk) begin
    if (en6) begin
      result.pixel_out <= ring ? 8'd0 : s5_gray;
      result.on_ring   <= ring;
    end
  end

  `GERO_ASSERT_SAME(a_ring_blanks, clk, rst, result_valid && result.on_ring, result.pixel_out == 8'd0)
  `GERO_ASSERT_NEXT(a_accept_fills, clk, rst, pixel_valid && pixel_ready, v1)
  `GERO_ASSERT_NEXT(a_stall_holds_s5, clk, rst, v5 && result_valid && !result_ready, v5 && result_valid)
  `GERO_ASSERT_SAME(a_ready_when_empty, clk, rst, !v1 || !result_valid, pixel_ready)

endmodule

`default_nettype wire
